// ----- design/gic_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the gamepad input conditioner.
// No dependencies; imported by every module of the block.
package gic_pkg;

  localparam int PadsDefault = 4;
  localparam int AnalogButtonsDefault = 8;

  localparam logic [14:0] FULL_SCALE    = 15'h7fff;
  localparam logic [14:0] PRESS_RAW_MAX = 15'd255;
  localparam logic [14:0] DZ_RESET      = 15'd13107;
  localparam logic [14:0] SAT_RESET     = 15'd31129;
  localparam logic [14:0] THR_RESET     = 15'd2621;

  localparam logic [1:0] REG_DEAD_ZONE  = 2'd0;
  localparam logic [1:0] REG_SATURATION = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;

  typedef enum logic [1:0] {
    KIND_BUTTON   = 2'd0,
    KIND_ANALOG   = 2'd1,
    KIND_STICK    = 2'd2,
    KIND_PRESSURE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [14:0] dead_zone;
    logic [14:0] saturation;
    logic [14:0] press_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         pad;
    logic               connected;
    logic [15:0]        buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [63:0]        pressures;
  } frame_t;

  typedef struct packed {
    logic [1:0]         pad;
    kind_t              kind;
    logic [3:0]         gadget;
    logic               pressed;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
  } event_t;

  typedef struct packed {
    logic        start;
    logic [29:0] num;
    logic [14:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic   push;
    event_t ev;
    logic   flush;
  } emit_req_t;

  typedef struct packed {
    logic push_ack;
    logic flush_ack;
  } emit_rsp_t;

endpackage

// ----- design/gamepad_input_conditioner_top.sv -----
`timescale 1ns / 1ps
// Gamepad input conditioner top level: stream in, event stream out, APB config.
// Depends on gic_pkg, gic_regs, gic_seq, gic_div, gic_emit.
//
// Usage:
//   Slave channel takes one polled frame per transaction (tuser = connected).
//   Master channel gives change events in order; tlast marks the frame's final
//   event. A frame with no changes gives no transaction.
//   s_tready is high only while the sequencer is idle; one frame is worked on
//   at a time. A disconnected frame or a pad beyond PADS is taken without leaving idle.
//   A connected frame goes through one idle step, 16 button steps, one step per
//   axis (with a wait when it needs the shared divider), two stick steps, the
//   steps per pressure (scale, condition with an optional division, event,
//   optional analog event) and one flush step.
//   The last event of a frame is held until the frame ends, then leaves with
//   tlast. A stalled m_tready holds the output register and the sequencer
//   waits on its next event; nothing is dropped.
//   Reset clears all stored pad values, the stamp counter, and loads the
//   default dead zone, saturation and press threshold.
//   Registers: 0x0 dead_zone, 0x4 saturation, 0x8 press_threshold.
module gamepad_input_conditioner_top #(
  parameter int PADS = gic_pkg::PadsDefault,
  parameter int ANALOG_BUTTONS = gic_pkg::AnalogButtonsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pad[1:0], buttons[17:2], left_x[33:18], left_y[49:34], right_x[65:50],
  // right_y[81:66], pressures[145:82], zero fill
  input  logic [151:0] s_tdata,
  // connected[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // event_pad[1:0], gadget[5:2], pressed[6], value_x[22:7], value_y[38:23],
  // stamp[70:39], zero fill
  output logic [71:0]  m_tdata,
  // kind[1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import gic_pkg::*;

  cfg_t      cfg;
  frame_t    frame;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  emit_req_t emit_req;
  emit_rsp_t emit_rsp;
  event_t    out_ev;
  logic [31:0] out_stamp;

  assign frame.pad       = s_tdata[1:0];
  assign frame.connected = s_tuser[0];
  assign frame.buttons   = s_tdata[17:2];
  assign frame.left_x    = s_tdata[33:18];
  assign frame.left_y    = s_tdata[49:34];
  assign frame.right_x   = s_tdata[65:50];
  assign frame.right_y   = s_tdata[81:66];
  assign frame.pressures = s_tdata[145:82];

  gic_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  gic_seq #(.PADS(PADS), .ANALOG_BUTTONS(ANALOG_BUTTONS)) u_seq (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_frame(frame), .cfg(cfg), .div_req(div_req), .div_rsp(div_rsp),
    .emit_req(emit_req), .emit_rsp(emit_rsp)
  );

  gic_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  gic_emit u_emit (
    .clk(clk), .rst(rst), .req(emit_req), .rsp(emit_rsp),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_ev(out_ev),
    .out_stamp(out_stamp), .out_last(m_tlast)
  );

  assign m_tdata = {1'b0, out_stamp, out_ev.value_y, out_ev.value_x,
                    out_ev.pressed, out_ev.gadget, out_ev.pad};
  assign m_tuser = out_ev.kind;

endmodule

// ----- design/gic_regs.sv -----
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
// Depends on gic_pkg.
module gic_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output gic_pkg::cfg_t cfg
);
  import gic_pkg::*;

  logic [1:0] ridx;
  logic       wr;

  assign ridx   = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone       <= DZ_RESET;
      cfg.saturation      <= SAT_RESET;
      cfg.press_threshold <= THR_RESET;
    end else if (wr) begin
      case (ridx)
        REG_DEAD_ZONE:  cfg.dead_zone       <= pwdata[14:0];
        REG_SATURATION: cfg.saturation      <= pwdata[14:0];
        REG_THRESHOLD:  cfg.press_threshold <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_DEAD_ZONE:  prdata = {17'd0, cfg.dead_zone};
      REG_SATURATION: prdata = {17'd0, cfg.saturation};
      REG_THRESHOLD:  prdata = {17'd0, cfg.press_threshold};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/gic_div.sv -----
`timescale 1ns / 1ps
// Shared restoring divider: 30-bit numerator by 15-bit divisor, 15-bit quotient,
// three quotient bits per cycle. Depends on gic_pkg.
module gic_div (
  input  logic              clk,
  input  logic              rst,
  input  gic_pkg::div_req_t req,
  output gic_pkg::div_rsp_t rsp
);
  import gic_pkg::*;

  localparam int BitsPerCycle = 3;
  localparam int Rounds = 15 / BitsPerCycle;

  logic [14:0] rem;
  logic [14:0] sh;
  logic [14:0] den;
  logic [2:0]  cnt;
  logic        busy;
  logic        done;
  logic [14:0] r;
  logic [14:0] s;
  logic [15:0] t;

  always_comb begin
    r = rem;
    s = sh;
    t = 16'd0;
    for (int k = 0; k < BitsPerCycle; k++) begin
      t = {r, s[14]};
      s = {s[13:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        s[0] = 1'b1;
      end
      r = t[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= busy && (cnt == 3'(Rounds - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(Rounds - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num[29:15];
      sh  <= req.num[14:0];
      den <= req.den;
    end else if (busy) begin
      rem <= r;
      sh  <= s;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = sh;

endmodule

// ----- design/gic_emit.sv -----
`timescale 1ns / 1ps
// Event output stage: one held event so the frame's final event gets tlast,
// stamp counter, and the master-side output register. Depends on gic_pkg.
module gic_emit (
  input  logic               clk,
  input  logic               rst,
  input  gic_pkg::emit_req_t req,
  output gic_pkg::emit_rsp_t rsp,
  output logic               out_valid,
  input  logic               out_ready,
  output gic_pkg::event_t    out_ev,
  output logic [31:0]        out_stamp,
  output logic               out_last
);
  import gic_pkg::*;

  logic        pend_valid;
  event_t      pend_ev;
  logic [31:0] pend_stamp;
  logic [31:0] count;
  logic        can_load;
  logic        load_out;

  assign can_load      = !out_valid || out_ready;
  assign rsp.push_ack  = req.push && (!pend_valid || can_load);
  assign rsp.flush_ack = req.flush && (!pend_valid || can_load);
  assign load_out      = pend_valid && (rsp.push_ack || rsp.flush_ack);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      count      <= 32'd0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (rsp.push_ack) begin
        pend_valid <= 1'b1;
        count      <= count + 32'd1;
      end else if (rsp.flush_ack && pend_valid) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.push_ack) begin
      pend_ev    <= req.ev;
      pend_stamp <= count;
      if (pend_valid) begin
        out_ev    <= pend_ev;
        out_stamp <= pend_stamp;
        out_last  <= 1'b0;
      end
    end else if (rsp.flush_ack && pend_valid) begin
      out_ev    <= pend_ev;
      out_stamp <= pend_stamp;
      out_last  <= 1'b1;
    end
  end

endmodule

// ----- design/gic_seq.sv -----
`timescale 1ns / 1ps
// Frame sequencer: per-pad stored state, conditioning steps around the shared
// divider, and event ordering. Depends on gic_pkg.
module gic_seq #(
  parameter int PADS = gic_pkg::PadsDefault,
  parameter int ANALOG_BUTTONS = gic_pkg::AnalogButtonsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gic_pkg::frame_t    in_frame,
  input  gic_pkg::cfg_t      cfg,
  output gic_pkg::div_req_t  div_req,
  input  gic_pkg::div_rsp_t  div_rsp,
  output gic_pkg::emit_req_t emit_req,
  input  gic_pkg::emit_rsp_t emit_rsp
);
  import gic_pkg::*;

  localparam int PAD_W = (PADS > 1) ? $clog2(PADS) : 1;
  localparam int AB_W = (ANALOG_BUTTONS > 1) ? $clog2(ANALOG_BUTTONS) : 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_BTN   = 11'b00000000010,
    S_AX    = 11'b00000000100,
    S_AXW   = 11'b00000001000,
    S_STICK = 11'b00000010000,
    S_PS    = 11'b00000100000,
    S_PC    = 11'b00001000000,
    S_PCW   = 11'b00010000000,
    S_PE    = 11'b00100000000,
    S_PX    = 11'b01000000000,
    S_FLUSH = 11'b10000000000
  } state_t;

  state_t state;
  frame_t fr;
  logic [3:0] idx;
  logic signed [15:0] ax [4];
  logic signed [15:0] raw_ax [4];
  logic signed [15:0] pscale;
  logic signed [15:0] cur;
  logic neg_q;

  logic [15:0] prev_btn [PADS];
  logic signed [15:0] prev_ax [PADS][4];
  logic [15:0] prev_pr [PADS][ANALOG_BUTTONS];

  logic [PAD_W-1:0] pi;
  logic [AB_W-1:0] bi;
  logic [15:0] change;
  logic signed [15:0] cx;
  logic c_neg;
  logic [15:0] mag;
  logic [15:0] diff;
  logic c_zero;
  logic c_full;
  logic signed [15:0] c_imm;
  logic signed [15:0] q_signed;
  logic [7:0] praw;
  logic [6:0] pfrac;
  logic [15:0] old_pr;
  logic [15:0] thr;
  logic rise;
  logic fall;
  logic stick_chg;
  logic [1:0] sx;
  logic last_pr;

  assign pi = PAD_W'(fr.pad);
  assign bi = idx[AB_W-1:0];
  assign raw_ax[0] = fr.left_x;
  assign raw_ax[1] = fr.left_y;
  assign raw_ax[2] = fr.right_x;
  assign raw_ax[3] = fr.right_y;
  assign change = fr.buttons ^ prev_btn[pi];
  assign in_ready = (state == S_IDLE);

  assign cx = (state == S_AX) ? raw_ax[idx[1:0]] : pscale;
  assign c_neg = cx[15];
  assign mag = c_neg ? 16'(-cx) : 16'(cx);
  assign diff = mag - {1'b0, cfg.dead_zone};
  assign c_zero = mag <= {1'b0, cfg.dead_zone};
  assign c_full = mag >= {1'b0, cfg.saturation};
  assign c_imm = c_zero ? 16'sd0 :
                 (c_neg ? -$signed({1'b0, FULL_SCALE}) : $signed({1'b0, FULL_SCALE}));
  assign q_signed = neg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});

  // p * 32767 / 255 = 128p + floor(127p / 255); the fraction term is p/2,
  // less one for a nonzero even p
  assign praw = fr.pressures[{idx[2:0], 3'b000} +: 8];
  assign pfrac = praw[7:1] - {6'd0, (praw != 8'd0) && !praw[0]};
  assign old_pr = prev_pr[pi][bi];
  assign thr = {1'b0, cfg.press_threshold};
  assign rise = (old_pr < thr) && (16'(cur) >= thr);
  assign fall = (old_pr >= thr) && (16'(cur) < thr);
  assign sx = {idx[0], 1'b0};
  assign stick_chg = (ax[sx] != prev_ax[pi][sx]) || (ax[sx + 2'd1] != prev_ax[pi][sx + 2'd1]);
  assign last_pr = (idx == 4'(ANALOG_BUTTONS - 1));

  always_comb begin
    div_req.start = 1'b0;
    div_req.num = {diff[14:0], 15'd0} - {15'd0, diff[14:0]};
    div_req.den = cfg.saturation - cfg.dead_zone;
    case (state)
      S_AX, S_PC: div_req.start = !c_zero && !c_full;
      default: ;
    endcase
  end

  always_comb begin
    emit_req.push = 1'b0;
    emit_req.flush = 1'b0;
    emit_req.ev.pad = fr.pad;
    emit_req.ev.kind = KIND_BUTTON;
    emit_req.ev.gadget = idx;
    emit_req.ev.pressed = 1'b0;
    emit_req.ev.value_x = 16'sd0;
    emit_req.ev.value_y = 16'sd0;
    case (state)
      S_BTN: begin
        emit_req.push = change[idx];
        emit_req.ev.pressed = fr.buttons[idx];
      end
      S_STICK: begin
        emit_req.push = stick_chg;
        emit_req.ev.kind = KIND_STICK;
        emit_req.ev.gadget = {3'd0, idx[0]};
        emit_req.ev.value_x = ax[sx];
        emit_req.ev.value_y = ax[sx + 2'd1];
      end
      S_PE: begin
        emit_req.push = (16'(cur) != old_pr);
        emit_req.ev.kind = KIND_PRESSURE;
        emit_req.ev.value_x = cur;
      end
      S_PX: begin
        emit_req.push = 1'b1;
        emit_req.ev.kind = KIND_ANALOG;
        emit_req.ev.pressed = rise;
      end
      S_FLUSH: emit_req.flush = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= 4'd0;
      for (int p = 0; p < PADS; p++) begin
        prev_btn[p] <= 16'd0;
        for (int k = 0; k < 4; k++) prev_ax[p][k] <= 16'sd0;
        for (int k = 0; k < ANALOG_BUTTONS; k++) prev_pr[p][k] <= 16'd0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          idx <= 4'd0;
          if (in_valid && int'(in_frame.pad) < PADS) begin
            if (in_frame.connected) begin
              state <= S_BTN;
            end else begin
              prev_btn[PAD_W'(in_frame.pad)] <= 16'd0;
              for (int k = 0; k < 4; k++) prev_ax[PAD_W'(in_frame.pad)][k] <= 16'sd0;
              for (int k = 0; k < ANALOG_BUTTONS; k++) begin
                prev_pr[PAD_W'(in_frame.pad)][k] <= 16'd0;
              end
            end
          end
        end
        S_BTN: begin
          if (!change[idx] || emit_rsp.push_ack) begin
            if (idx == 4'd15) begin
              prev_btn[pi] <= fr.buttons;
              idx <= 4'd0;
              state <= S_AX;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        S_AX: begin
          neg_q <= c_neg;
          if (c_zero || c_full) begin
            ax[idx[1:0]] <= c_imm;
            if (idx == 4'd3) begin
              idx <= 4'd0;
              state <= S_STICK;
            end else begin
              idx <= idx + 4'd1;
            end
          end else begin
            state <= S_AXW;
          end
        end
        S_AXW: begin
          if (div_rsp.done) begin
            ax[idx[1:0]] <= q_signed;
            if (idx == 4'd3) begin
              idx <= 4'd0;
              state <= S_STICK;
            end else begin
              idx <= idx + 4'd1;
              state <= S_AX;
            end
          end
        end
        S_STICK: begin
          if (!stick_chg || emit_rsp.push_ack) begin
            if (idx[0]) begin
              for (int k = 0; k < 4; k++) prev_ax[pi][k] <= ax[k];
              idx <= 4'd0;
              state <= S_PS;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        S_PS: begin
          pscale <= $signed({1'b0, praw, 7'd0} + {9'd0, pfrac});
          state <= S_PC;
        end
        S_PC: begin
          neg_q <= c_neg;
          if (c_zero || c_full) begin
            cur <= c_imm;
            state <= S_PE;
          end else begin
            state <= S_PCW;
          end
        end
        S_PCW: begin
          if (div_rsp.done) begin
            cur <= q_signed;
            state <= S_PE;
          end
        end
        S_PE: begin
          if (16'(cur) == old_pr || emit_rsp.push_ack) begin
            if (16'(cur) != old_pr && (rise || fall)) begin
              state <= S_PX;
            end else begin
              prev_pr[pi][bi] <= 16'(cur);
              idx <= idx + 4'd1;
              state <= last_pr ? S_FLUSH : S_PS;
            end
          end
        end
        S_PX: begin
          if (emit_rsp.push_ack) begin
            prev_pr[pi][bi] <= 16'(cur);
            idx <= idx + 4'd1;
            state <= last_pr ? S_FLUSH : S_PS;
          end
        end
        S_FLUSH: begin
          if (emit_rsp.flush_ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) fr <= in_frame;
  end

endmodule
